// File: rtl/mrt_pkg.sv
`timescale 1ns / 1ps
package mrt_pkg;

   localparam int TABLE_DEPTH   = 64;
   localparam int PAGE_SHIFT    = 12;
   localparam int NAME_TAG_BITS = 16;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ITER_W = $clog2(TABLE_DEPTH + 3);

   localparam logic [63:0] ALL_ONES  = '1;
   localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

   typedef enum logic [2:0] {
      FUNC_ADD_CHECKED   = 3'd0,
      FUNC_ADD_UNCHECKED = 3'd1,
      FUNC_FIND_FREE     = 3'd2,
      FUNC_FIND_OVERLAP  = 3'd3,
      FUNC_FIND_CONTAIN  = 3'd4,
      FUNC_OPTIMIZE      = 3'd5,
      FUNC_UNUSED6       = 3'd6,
      FUNC_UNUSED7       = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_INVALID  = 3'd1,
      STAT_ABOVE    = 3'd2,
      STAT_CLAMPED  = 3'd3,
      STAT_EMPTY    = 3'd4,
      STAT_FULL     = 3'd5,
      STAT_OVERLAP  = 3'd6,
      STAT_NOTFOUND = 3'd7
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_ADD_CHK, S_SCAN, S_ADD_EVAL, S_ADD_WRITE,
      S_FF_ALIGN, S_FF_SUM, S_FF_CHECK, S_FF_EVAL,
      S_SORT_KEY, S_SORT_KEYW, S_SORT_CMP, S_SORT_PUT,
      S_MRG_FIRST, S_MRG_FIRSTW, S_MRG_STEP, S_MRG_LAST, S_DONE
   } state_type;

   typedef struct packed {
      logic [63:0]              rbegin;
      logic [63:0]              rend;
      logic [2:0]               rtype;
      logic [7:0]               subtype;
      logic [NAME_TAG_BITS-1:0] name;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam logic [3:0] ADDR_UPPER_LIMIT = 4'd0;

endpackage

// File: rtl/mrt_if.sv
`timescale 1ns / 1ps
interface mrt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [63:0] range_begin;
   logic [63:0] range_end;
   logic [63:0] alloc_size;
   logic [5:0]  align_log2;
   logic [2:0]  region_type;
   logic [7:0]  region_subtype;
   logic [15:0] name_tag;
   logic        overlap_ok;

   modport source (output valid, func, range_begin, range_end, alloc_size, align_log2,
                   region_type, region_subtype, name_tag, overlap_ok, input ready);
   modport sink (input valid, func, range_begin, range_end, alloc_size, align_log2,
                 region_type, region_subtype, name_tag, overlap_ok, output ready);
endinterface

interface mrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] address;
   logic [5:0]  found_index;
   logic [63:0] entry_begin;
   logic [63:0] entry_end;
   logic [2:0]  entry_type;
   logic [6:0]  count_now;

   modport source (output valid, status, address, found_index, entry_begin, entry_end,
                   entry_type, count_now, input ready);
   modport sink (input valid, status, address, found_index, entry_begin, entry_end,
                 entry_type, count_now, output ready);
endinterface

// File: rtl/mrt_ram.sv
`timescale 1ns / 1ps
module mrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/memory_region_table_top.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake        | Payload
// req_chan | in  | valid/ready      | func, range, alloc_size, align, type, subtype, tag
// rsp_chan | out | valid/ready      | status, address, found entry, count_now
// csr      | in  | APB, pready = 1  | upper_limit at byte address 0 (64 bit)
//
// One request at a time. Lookups make one table walk through the single read port,
// as do adds unless overlap is allowed. Find free makes up to 66 table walks.
// Optimize is an insertion sort (up to about count^2/2 entry moves), then a merge
// walk. Reset is synchronous and empties the table; no clearing pass. A request is
// taken while the previous response still waits; completion stalls until the
// response register is free.
module memory_region_table_top (
   input  logic        clock,
   input  logic        reset,
   mrt_req_if.sink     req_chan,
   mrt_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import mrt_pkg::*;

   state_type   state_ff, state_in;
   func_type    func_ff, func_in;
   logic [63:0] b_ff, b_in, e_ff, e_in, size_ff, size_in;
   logic [5:0]  align_ff, align_in;
   logic [2:0]  ty_ff, ty_in;
   logic [7:0]  sub_ff, sub_in;
   logic [NAME_TAG_BITS-1:0] nm_ff, nm_in;
   logic        mayov_ff, mayov_in;
   status_type  code_ff, code_in, status_ff, status_in;
   logic [63:0] addr_ff, addr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic        pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic        hit_ff, hit_in;
   logic [IDX_W-1:0] hidx_ff, hidx_in;
   entry_type   hent_ff, hent_in;
   logic        have_ff, have_in;
   logic [63:0] best_ff, best_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [63:0] tend_ff, tend_in;
   logic [64:0] sum_ff, sum_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   entry_type   key_ff, key_in, cur_ff, cur_in;
   logic [63:0] ul_ff, ul_in;
   logic        rv_ff, rv_in;
   status_type  rstat_ff, rstat_in;
   logic [63:0] raddr_ff, raddr_in;
   logic [5:0]  rfidx_ff, rfidx_in;
   logic [63:0] rbeg_ff, rbeg_in, rend_ff, rend_in;
   logic [2:0]  rty_ff, rty_in;
   logic [6:0]  rcnt_ff, rcnt_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   entry_type        ram_wdata, rdata;
   logic [ENTRY_W-1:0] rdata_raw;

   mrt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rdata_raw)
   );
   assign rdata = entry_type'(rdata_raw);

   // scan compare on the entry returned by the RAM
   logic [63:0] q_end;
   logic        is_contain, ent_match, ent_above;
   assign q_end      = (func_ff == FUNC_FIND_FREE) ? tend_ff : e_ff;
   assign is_contain = (func_ff == FUNC_FIND_CONTAIN);
   assign ent_match  = is_contain ? (rdata.rbegin <= b_ff && rdata.rend >= e_ff)
                                  : (rdata.rbegin <= q_end && b_ff <= rdata.rend);
   assign ent_above  = rdata.rend > b_ff && (!have_ff || rdata.rend < best_ff);

   // merge test between held entry and the one read
   logic        alike, adjacent;
   logic [63:0] up_end;
   assign alike    = rdata.rtype == cur_ff.rtype && rdata.subtype == cur_ff.subtype
                     && rdata.name == cur_ff.name;
   assign up_end   = (cur_ff.rend + PAGE_MASK) & ~PAGE_MASK;
   assign adjacent = (cur_ff.rend > ALL_ONES - PAGE_MASK)
                     || (up_end >= (rdata.rbegin & ~PAGE_MASK));

   logic cfg_wr;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_UPPER_LIMIT) ? ul_ff : 64'd0;

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      logic [63:0] mask, ulm1, last;
      logic        scan_done, fail;
      logic        show;
      state_in = state_ff; func_in = func_ff; b_in = b_ff; e_in = e_ff;
      size_in = size_ff; align_in = align_ff; ty_in = ty_ff; sub_in = sub_ff;
      nm_in = nm_ff; mayov_in = mayov_ff; code_in = code_ff; status_in = status_ff;
      addr_in = addr_ff; count_in = count_ff; scan_in = scan_ff; pend_in = 1'b0;
      pidx_in = pidx_ff; hit_in = hit_ff; hidx_in = hidx_ff; hent_in = hent_ff;
      have_in = have_ff; best_in = best_ff; iter_in = iter_ff; tend_in = tend_ff;
      sum_in = sum_ff; i_in = i_ff; j_in = j_ff; key_in = key_ff; cur_in = cur_ff;
      ul_in = ul_ff; rv_in = rv_ff; rstat_in = rstat_ff; raddr_in = raddr_ff;
      rfidx_in = rfidx_ff; rbeg_in = rbeg_ff; rend_in = rend_ff; rty_in = rty_ff;
      rcnt_in = rcnt_ff;
      ram_we = 1'b0; ram_waddr = '0; ram_wdata = key_ff; ram_raddr = '0;
      mask = (64'd1 << align_ff) - 64'd1;
      ulm1 = ul_ff - 64'd1;
      last = sum_ff[63:0] - 64'd1;
      scan_done = 1'b0; fail = 1'b0; show = 1'b0;

      if (cfg_wr && paddr == ADDR_UPPER_LIMIT) begin
         ul_in = pwdata;
      end
      if (rv_ff && rsp_chan.ready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               func_in  = func_type'(req_chan.func);
               b_in     = req_chan.range_begin;
               e_in     = req_chan.range_end;
               size_in  = req_chan.alloc_size;
               align_in = req_chan.align_log2;
               ty_in    = req_chan.region_type;
               sub_in   = req_chan.region_subtype;
               nm_in    = req_chan.name_tag[NAME_TAG_BITS-1:0];
               mayov_in = req_chan.overlap_ok;
               addr_in  = '0;
               code_in  = STAT_OK;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            scan_in = '0; hit_in = 1'b0; have_in = 1'b0; iter_in = '0;
            unique case (func_ff)
               FUNC_ADD_CHECKED: begin
                  if (b_ff > e_ff) begin
                     status_in = STAT_INVALID; state_in = S_DONE;
                  end else if (b_ff >= ul_ff) begin
                     status_in = STAT_ABOVE; state_in = S_DONE;
                  end else begin
                     if (e_ff >= ulm1) begin
                        if (e_ff != ulm1) code_in = STAT_CLAMPED;
                        e_in = ulm1;
                     end
                     state_in = S_ADD_CHK;
                  end
               end
               FUNC_ADD_UNCHECKED: state_in = S_ADD_CHK;
               FUNC_FIND_FREE:     state_in = S_FF_ALIGN;
               FUNC_FIND_OVERLAP, FUNC_FIND_CONTAIN: state_in = S_SCAN;
               FUNC_OPTIMIZE: begin
                  status_in = STAT_OK;
                  i_in = CNT_W'(1);
                  state_in = (count_ff < CNT_W'(2)) ? S_DONE : S_SORT_KEY;
               end
               default: begin
                  status_in = STAT_INVALID; state_in = S_DONE;
               end
            endcase
         end
         S_ADD_CHK: begin
            if (b_ff == e_ff) begin
               status_in = STAT_EMPTY; state_in = S_DONE;
            end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
               status_in = STAT_FULL; state_in = S_DONE;
            end else if (mayov_ff) begin
               state_in = S_ADD_WRITE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_ff < count_ff) begin
               ram_raddr = scan_ff[IDX_W-1:0];
               pend_in   = 1'b1;
               pidx_in   = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (ent_match && !hit_ff) begin
                  hit_in = 1'b1; hidx_in = pidx_ff; hent_in = rdata;
               end
               if (ent_above) begin
                  have_in = 1'b1; best_in = rdata.rend;
               end
            end
            scan_done = (scan_ff == count_ff) && !pend_ff;
            if (scan_done) begin
               priority case (func_ff)
                  FUNC_FIND_FREE: state_in = S_FF_EVAL;
                  FUNC_FIND_OVERLAP, FUNC_FIND_CONTAIN: begin
                     status_in = hit_ff ? STAT_OK : STAT_NOTFOUND;
                     state_in  = S_DONE;
                  end
                  default: state_in = S_ADD_EVAL;
               endcase
            end
         end
         S_ADD_EVAL: begin
            if (hit_ff && !(hent_ff.rbegin <= b_ff && hent_ff.rend >= e_ff
                            && hent_ff.rtype == ty_ff)) begin
               status_in = STAT_OVERLAP; state_in = S_DONE;
            end else begin
               state_in = S_ADD_WRITE;
            end
         end
         S_ADD_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[IDX_W-1:0];
            ram_wdata = '{rbegin: b_ff, rend: e_ff, rtype: ty_ff, subtype: sub_ff,
                          name: nm_ff};
            count_in  = count_ff + CNT_W'(1);
            status_in = code_ff;
            state_in  = S_DONE;
         end
         S_FF_ALIGN: begin
            if (b_ff > ~mask) begin
               status_in = STAT_NOTFOUND; state_in = S_DONE;
            end else begin
               b_in = (b_ff + mask) & ~mask;
               state_in = S_FF_SUM;
            end
         end
         S_FF_SUM: begin
            sum_in   = {1'b0, b_ff} + {1'b0, size_ff};
            state_in = S_FF_CHECK;
         end
         S_FF_CHECK: begin
            fail = (size_ff != 64'd0 && sum_ff[64] && sum_ff[63:0] != 64'd0)
                   || (!(size_ff == 64'd0 && b_ff == 64'd0) && last > e_ff);
            tend_in = sum_ff[64] ? ALL_ONES : sum_ff[63:0];
            scan_in = '0; hit_in = 1'b0; have_in = 1'b0;
            if (fail) begin
               status_in = STAT_NOTFOUND; state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_FF_EVAL: begin
            if (!hit_ff) begin
               addr_in = b_ff; status_in = STAT_OK; state_in = S_DONE;
            end else if (!have_ff || iter_ff == ITER_W'(TABLE_DEPTH + 1)) begin
               status_in = STAT_NOTFOUND; state_in = S_DONE;
            end else begin
               b_in = best_ff; iter_in = iter_ff + ITER_W'(1); state_in = S_FF_ALIGN;
            end
         end
         S_SORT_KEY: begin
            ram_raddr = i_ff[IDX_W-1:0];
            state_in  = S_SORT_KEYW;
         end
         S_SORT_KEYW: begin
            key_in    = rdata;
            j_in      = i_ff;
            ram_raddr = IDX_W'(i_ff - CNT_W'(1));
            state_in  = S_SORT_CMP;
         end
         S_SORT_CMP, S_SORT_PUT: begin
            if (state_ff == S_SORT_CMP && rdata.rbegin > key_ff.rbegin) begin
               ram_we    = 1'b1;
               ram_waddr = j_ff[IDX_W-1:0];
               ram_wdata = rdata;
               j_in      = j_ff - CNT_W'(1);
               if (j_ff > CNT_W'(1)) begin
                  ram_raddr = IDX_W'(j_ff - CNT_W'(2));
               end else begin
                  state_in = S_SORT_PUT;
               end
            end else begin
               ram_we    = 1'b1;
               ram_waddr = j_ff[IDX_W-1:0];
               ram_wdata = key_ff;
               i_in      = i_ff + CNT_W'(1);
               state_in  = (i_ff + CNT_W'(1) < count_ff) ? S_SORT_KEY : S_MRG_FIRST;
            end
         end
         S_MRG_FIRST: begin
            ram_raddr = '0;
            state_in  = S_MRG_FIRSTW;
         end
         S_MRG_FIRSTW: begin
            cur_in    = rdata;
            i_in      = CNT_W'(1);
            j_in      = '0;
            ram_raddr = IDX_W'(1);
            state_in  = S_MRG_STEP;
         end
         S_MRG_STEP: begin
            if (alike && adjacent) begin
               if (rdata.rend > cur_ff.rend) cur_in.rend = rdata.rend;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = j_ff[IDX_W-1:0];
               ram_wdata = cur_ff;
               j_in      = j_ff + CNT_W'(1);
               cur_in    = rdata;
            end
            i_in = i_ff + CNT_W'(1);
            if (i_ff + CNT_W'(1) < count_ff) begin
               ram_raddr = IDX_W'(i_ff + CNT_W'(1));
            end else begin
               state_in = S_MRG_LAST;
            end
         end
         S_MRG_LAST: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[IDX_W-1:0];
            ram_wdata = cur_ff;
            count_in  = j_ff + CNT_W'(1);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || rsp_chan.ready) begin
               show = (func_ff == FUNC_FIND_OVERLAP || func_ff == FUNC_FIND_CONTAIN)
                      && hit_ff;
               rv_in    = 1'b1;
               rstat_in = status_ff;
               raddr_in = addr_ff;
               rfidx_in = show ? 6'(hidx_ff) : 6'd0;
               rbeg_in  = show ? hent_ff.rbegin : 64'd0;
               rend_in  = show ? hent_ff.rend : 64'd0;
               rty_in   = show ? hent_ff.rtype : 3'd0;
               rcnt_in  = 7'(count_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
         ul_ff    <= ALL_ONES;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         ul_ff    <= ul_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; b_ff <= b_in; e_ff <= e_in; size_ff <= size_in;
      align_ff <= align_in; ty_ff <= ty_in; sub_ff <= sub_in; nm_ff <= nm_in;
      mayov_ff <= mayov_in; code_ff <= code_in; status_ff <= status_in;
      addr_ff <= addr_in; scan_ff <= scan_in; pidx_ff <= pidx_in; hit_ff <= hit_in;
      hidx_ff <= hidx_in; hent_ff <= hent_in; have_ff <= have_in; best_ff <= best_in;
      iter_ff <= iter_in; tend_ff <= tend_in; sum_ff <= sum_in; i_ff <= i_in;
      j_ff <= j_in; key_ff <= key_in; cur_ff <= cur_in; rstat_ff <= rstat_in;
      raddr_ff <= raddr_in; rfidx_ff <= rfidx_in; rbeg_ff <= rbeg_in;
      rend_ff <= rend_in; rty_ff <= rty_in; rcnt_ff <= rcnt_in;
   end

   assign rsp_chan.valid       = rv_ff;
   assign rsp_chan.status      = rstat_ff;
   assign rsp_chan.address     = raddr_ff;
   assign rsp_chan.found_index = rfidx_ff;
   assign rsp_chan.entry_begin = rbeg_ff;
   assign rsp_chan.entry_end   = rend_ff;
   assign rsp_chan.entry_type  = rty_ff;
   assign rsp_chan.count_now   = rcnt_ff;
endmodule

// File: rtl/mrt_checker.sv
`timescale 1ns / 1ps
module mrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [63:0] rsp_address,
   input logic [63:0] rsp_entry_begin,
   input logic [6:0]  rsp_count_now,
   input logic        pready
);
   import mrt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count_now <= 7'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NOTFOUND |-> rsp_address == 64'd0
                                                  && rsp_entry_begin == 64'd0)
      else $error("not found response carries data");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule

bind memory_region_table_top mrt_checker u_mrt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_address     (rsp_chan.address),
   .rsp_entry_begin (rsp_chan.entry_begin),
   .rsp_count_now   (rsp_chan.count_now),
   .pready          (pready)
);

// File: tb/mrt_checker.sv
`timescale 1ns / 1ps
module mrt_tb_checker (
   input  logic        clock,
   input  logic        reset,
   mrt_req_if          req,
   mrt_rsp_if          rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output int          errors,
   output int          pending,
   output int          responses
);
   import mrt_pkg::*;

   typedef struct {
      status_type  status;
      logic [63:0] address;
      logic [5:0]  found_index;
      logic [63:0] entry_begin;
      logic [63:0] entry_end;
      logic [2:0]  entry_type;
      logic [6:0]  count_now;
   } region_rsp_type;

   region_rsp_type rsp_queue[$];

   logic [63:0] limit_reg;
   logic [63:0] tbl_begin[TABLE_DEPTH];
   logic [63:0] tbl_end[TABLE_DEPTH];
   logic [2:0]  tbl_type[TABLE_DEPTH];
   logic [7:0]  tbl_sub[TABLE_DEPTH];
   logic [15:0] tbl_name[TABLE_DEPTH];
   int          tbl_count;

   function automatic int first_hit(input logic [63:0] b, input logic [63:0] e);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_begin[i] <= e && b <= tbl_end[i]) return i;
      return -1;
   endfunction

   function automatic int first_cover(input logic [63:0] b, input logic [63:0] e);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_begin[i] <= b && tbl_end[i] >= e) return i;
      return -1;
   endfunction

   function automatic status_type add_region(input logic [63:0] b, input logic [63:0] e,
                                             input logic [2:0] ty, input logic [7:0] sub,
                                             input logic [15:0] nm, input logic may_ov,
                                             input status_type ok_code);
      int hit;
      if (b == e) return STAT_EMPTY;
      if (tbl_count >= TABLE_DEPTH) return STAT_FULL;
      if (!may_ov) begin
         hit = first_hit(b, e);
         if (hit >= 0 && !(tbl_begin[hit] <= b && tbl_end[hit] >= e && tbl_type[hit] == ty))
            return STAT_OVERLAP;
      end
      tbl_begin[tbl_count] = b;
      tbl_end[tbl_count]   = e;
      tbl_type[tbl_count]  = ty;
      tbl_sub[tbl_count]   = sub;
      tbl_name[tbl_count]  = nm;
      tbl_count++;
      return ok_code;
   endfunction

   function automatic bit free_search(input logic [63:0] start, input logic [63:0] wend,
                                      input logic [63:0] size, input int align,
                                      output logic [63:0] found);
      logic [63:0] mask, tend, best;
      bit have;
      found = '0;
      mask = (64'd1 << align) - 64'd1;
      for (int it = 0; it < TABLE_DEPTH + 2; it++) begin
         if (start > ALL_ONES - mask) return 0;
         start = (start + mask) & ~mask;
         if (size == 0) begin
            if (start != 0 && start - 64'd1 > wend) return 0;
         end else begin
            if (start > ALL_ONES - (size - 64'd1)) return 0;
            if (start + (size - 64'd1) > wend) return 0;
         end
         tend = (start > ALL_ONES - size) ? ALL_ONES : start + size;
         if (first_hit(start, tend) < 0) begin
            found = start;
            return 1;
         end
         have = 0;
         best = ALL_ONES;
         for (int i = 0; i < tbl_count; i++)
            if (tbl_end[i] > start && (!have || tbl_end[i] < best)) begin
               best = tbl_end[i];
               have = 1;
            end
         if (!have) return 0;
         start = best;
      end
      return 0;
   endfunction

   function automatic bit page_near(input logic [63:0] first_end, input logic [63:0] next_begin);
      if (first_end > ALL_ONES - PAGE_MASK) return 1;
      return ((first_end + PAGE_MASK) & ~PAGE_MASK) >= (next_begin & ~PAGE_MASK);
   endfunction

   function automatic void compact_table();
      logic [63:0] b, e;
      logic [2:0]  t;
      logic [7:0]  s;
      logic [15:0] n;
      int j, c;
      for (int i = 1; i < tbl_count; i++) begin
         b = tbl_begin[i]; e = tbl_end[i]; t = tbl_type[i]; s = tbl_sub[i]; n = tbl_name[i];
         j = i;
         while (j > 0 && tbl_begin[j-1] > b) begin
            tbl_begin[j] = tbl_begin[j-1]; tbl_end[j] = tbl_end[j-1];
            tbl_type[j] = tbl_type[j-1]; tbl_sub[j] = tbl_sub[j-1]; tbl_name[j] = tbl_name[j-1];
            j--;
         end
         tbl_begin[j] = b; tbl_end[j] = e; tbl_type[j] = t; tbl_sub[j] = s; tbl_name[j] = n;
      end
      c = 0;
      while (c + 1 < tbl_count) begin
         if (tbl_type[c+1] == tbl_type[c] && tbl_sub[c+1] == tbl_sub[c] &&
             tbl_name[c+1] == tbl_name[c] && page_near(tbl_end[c], tbl_begin[c+1])) begin
            if (tbl_end[c+1] > tbl_end[c]) tbl_end[c] = tbl_end[c+1];
            for (int k = c + 1; k + 1 < tbl_count; k++) begin
               tbl_begin[k] = tbl_begin[k+1]; tbl_end[k] = tbl_end[k+1];
               tbl_type[k] = tbl_type[k+1]; tbl_sub[k] = tbl_sub[k+1];
               tbl_name[k] = tbl_name[k+1];
            end
            tbl_count--;
         end else begin
            c++;
         end
      end
   endfunction

   function automatic region_rsp_type predict_region_op();
      region_rsp_type r;
      logic [63:0] b, e, addr;
      status_type code;
      int hit;
      b = req.range_begin;
      e = req.range_end;
      hit = -1;
      addr = '0;
      r.status = STAT_OK;
      case (func_type'(req.func))
         FUNC_ADD_CHECKED: begin
            if (b > e) r.status = STAT_INVALID;
            else if (b >= limit_reg) r.status = STAT_ABOVE;
            else begin
               code = STAT_OK;
               if (e >= limit_reg - 64'd1) begin
                  if (e != limit_reg - 64'd1) code = STAT_CLAMPED;
                  e = limit_reg - 64'd1;
               end
               r.status = add_region(b, e, req.region_type, req.region_subtype, req.name_tag,
                                     req.overlap_ok, code);
            end
         end
         FUNC_ADD_UNCHECKED:
            r.status = add_region(b, e, req.region_type, req.region_subtype, req.name_tag,
                                  req.overlap_ok, STAT_OK);
         FUNC_FIND_FREE:
            if (!free_search(b, e, req.alloc_size, int'(req.align_log2), addr)) begin
               addr = '0;
               r.status = STAT_NOTFOUND;
            end
         FUNC_FIND_OVERLAP: begin
            hit = first_hit(b, e);
            if (hit < 0) r.status = STAT_NOTFOUND;
         end
         FUNC_FIND_CONTAIN: begin
            hit = first_cover(b, e);
            if (hit < 0) r.status = STAT_NOTFOUND;
         end
         FUNC_OPTIMIZE: compact_table();
         default: r.status = STAT_INVALID;
      endcase
      r.address = addr;
      if (hit >= 0) begin
         r.found_index = hit[5:0];
         r.entry_begin = tbl_begin[hit];
         r.entry_end   = tbl_end[hit];
         r.entry_type  = tbl_type[hit];
      end else begin
         r.found_index = '0;
         r.entry_begin = '0;
         r.entry_end   = '0;
         r.entry_type  = '0;
      end
      r.count_now = tbl_count[6:0];
      return r;
   endfunction

   assign pending = rsp_queue.size();

   always @(posedge clock) begin
      region_rsp_type exp_rsp;
      if (reset) begin
         limit_reg = ALL_ONES;
         tbl_count = 0;
         errors    <= 0;
         responses <= 0;
         rsp_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_UPPER_LIMIT)
            limit_reg = pwdata;
         if (rsp.valid && rsp.ready) begin
            responses <= responses + 1;
            if (rsp_queue.size() == 0) begin
               $display("%0t: unexpected response status=%0d", $time, rsp.status);
               errors <= errors + 1;
            end else begin
               exp_rsp = rsp_queue.pop_front();
               if (rsp.status !== exp_rsp.status || rsp.address !== exp_rsp.address ||
                   rsp.found_index !== exp_rsp.found_index ||
                   rsp.entry_begin !== exp_rsp.entry_begin ||
                   rsp.entry_end !== exp_rsp.entry_end ||
                   rsp.entry_type !== exp_rsp.entry_type ||
                   rsp.count_now !== exp_rsp.count_now) begin
                  $display("%0t: mismatch exp st=%0d addr=%h idx=%0d b=%h e=%h ty=%0d cnt=%0d",
                           $time, exp_rsp.status, exp_rsp.address, exp_rsp.found_index,
                           exp_rsp.entry_begin, exp_rsp.entry_end, exp_rsp.entry_type,
                           exp_rsp.count_now);
                  $display("%0t:          got st=%0d addr=%h idx=%0d b=%h e=%h ty=%0d cnt=%0d",
                           $time, rsp.status, rsp.address, rsp.found_index, rsp.entry_begin,
                           rsp.entry_end, rsp.entry_type, rsp.count_now);
                  errors <= errors + 1;
               end
            end
         end
         if (req.valid && req.ready)
            rsp_queue.push_back(predict_region_op());
      end
   end

endmodule

// File: tb/tb_memory_region_table_top.sv
`timescale 1ns / 1ps
module tb_memory_region_table_top;
   import mrt_pkg::*;

   typedef struct {
      func_type    f;
      logic [63:0] b, e, sz;
      logic [5:0]  al;
      logic [2:0]  ty;
      logic [7:0]  sub;
      logic [15:0] nm;
      logic        ov;
   } region_req_type;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;
   int          errors, pending, responses;
   int          gap_pct, stall_pct, sent;

   mrt_req_if req_chan ();
   mrt_rsp_if rsp_chan ();

   memory_region_table_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mrt_tb_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .pready    (pready),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .errors    (errors),
      .pending   (pending),
      .responses (responses)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #200ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic region_req_type mk(input func_type f, input logic [63:0] b,
                                         input logic [63:0] e, input logic [63:0] sz,
                                         input logic [5:0] al, input logic [2:0] ty,
                                         input logic [7:0] sub, input logic [15:0] nm,
                                         input logic ov);
      region_req_type r;
      r.f = f; r.b = b; r.e = e; r.sz = sz; r.al = al;
      r.ty = ty; r.sub = sub; r.nm = nm; r.ov = ov;
      return r;
   endfunction

   function automatic logic [63:0] pick_addr();
      int m;
      m = $urandom_range(99);
      if (m < 80)
         return {44'd0, 8'($urandom_range(255)), 12'd0} +
                (($urandom_range(3) == 0) ? 64'($urandom_range(4095)) : 64'd0);
      if (m < 86) return '0;
      if (m < 90) return ALL_ONES - 64'($urandom_range(8191));
      return {$urandom, $urandom};
   endfunction

   function automatic region_req_type pick_req();
      region_req_type r;
      logic [63:0] len, t;
      int w;
      w = $urandom_range(99);
      if (w < 30) r.f = FUNC_ADD_CHECKED;
      else if (w < 42) r.f = FUNC_ADD_UNCHECKED;
      else if (w < 62) r.f = FUNC_FIND_FREE;
      else if (w < 74) r.f = FUNC_FIND_OVERLAP;
      else if (w < 86) r.f = FUNC_FIND_CONTAIN;
      else if (w < 96) r.f = FUNC_OPTIMIZE;
      else r.f = ($urandom_range(1) != 0) ? FUNC_UNUSED6 : FUNC_UNUSED7;
      r.b = pick_addr();
      case ($urandom_range(9))
         0: len = 64'd0;
         1: len = {$urandom, $urandom};
         2: len = 64'($urandom_range(4095));
         default: len = 64'($urandom_range(8)) * 64'h1000 + 64'hfff;
      endcase
      r.e = (r.b > ALL_ONES - len) ? ALL_ONES : r.b + len;
      if ($urandom_range(99) < 8) begin
         t = r.b; r.b = r.e; r.e = t;
      end
      if (r.f == FUNC_FIND_FREE && $urandom_range(1) == 0) r.e = r.b + 64'h4_0000;
      case ($urandom_range(9))
         0: r.sz = {$urandom, $urandom};
         1: r.sz = 64'd0;
         default: r.sz = 64'($urandom_range(16'h3000));
      endcase
      r.al = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(14));
      r.ty = ($urandom_range(4) == 0) ? 3'($urandom_range(6)) : 3'($urandom_range(1)) + 3'd5;
      r.sub = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(1));
      r.nm = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1));
      r.ov = ($urandom_range(99) < 60);
      return r;
   endfunction

   task automatic send_req(input region_req_type r);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid          = 1'b1;
      req_chan.func           = r.f;
      req_chan.range_begin    = r.b;
      req_chan.range_end      = r.e;
      req_chan.alloc_size     = r.sz;
      req_chan.align_log2     = r.al;
      req_chan.region_type    = r.ty;
      req_chan.region_subtype = r.sub;
      req_chan.name_tag       = r.nm;
      req_chan.overlap_ok     = r.ov;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
   endtask

   task automatic write_limit(input logic [63:0] v);
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; paddr = ADDR_UPPER_LIMIT; pwdata = v;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   region_req_type directed[$];
   logic [63:0] limits[6];

   initial begin
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_chan.valid = 1'b0; req_chan.func = FUNC_ADD_CHECKED;
      req_chan.range_begin = '0; req_chan.range_end = '0; req_chan.alloc_size = '0;
      req_chan.align_log2 = '0; req_chan.region_type = '0; req_chan.region_subtype = '0;
      req_chan.name_tag = '0; req_chan.overlap_ok = 1'b0;
      rsp_chan.ready = 1'b0;
      gap_pct = 10; stall_pct = 46; sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed = {
         mk(FUNC_ADD_CHECKED, 64'h2000, 64'h1000, '0, '0, 3'd6, '0, '0, 1'b0),
         mk(FUNC_ADD_CHECKED, ALL_ONES, ALL_ONES, '0, '0, 3'd6, '0, '0, 1'b0),
         mk(FUNC_ADD_CHECKED, 64'h1000, 64'h1000, '0, '0, 3'd6, '0, '0, 1'b0),
         mk(FUNC_ADD_CHECKED, 64'h1000, 64'h2fff, '0, '0, 3'd6, 8'hff, 16'hffff, 1'b0),
         mk(FUNC_ADD_CHECKED, ALL_ONES - 64'h2000, ALL_ONES, '0, '0, 3'd5, '0, '0, 1'b0),
         mk(FUNC_ADD_UNCHECKED, 64'h2000, 64'h3fff, '0, '0, 3'd1, '0, '0, 1'b0),
         mk(FUNC_ADD_UNCHECKED, 64'h1800, 64'h2000, '0, '0, 3'd6, '0, '0, 1'b0),
         mk(FUNC_ADD_CHECKED, 64'h2000, 64'h4fff, '0, '0, 3'd1, '0, '0, 1'b1),
         mk(FUNC_ADD_UNCHECKED, 64'h5000, 64'h5fff, '0, '0, 3'd6, 8'hff, 16'hffff, 1'b0),
         mk(FUNC_FIND_FREE, 64'h0, 64'hffff, 64'h1000, 6'd12, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_FREE, 64'h10, 64'h0, 64'h0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_FREE, 64'h1, ALL_ONES, 64'h10, 6'd63, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_FREE, 64'h1000, ALL_ONES, ALL_ONES, '0, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_FREE, ALL_ONES - 64'h1000, ALL_ONES, 64'h1, '0, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_OVERLAP, 64'h1fff, 64'h2000, '0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_OVERLAP, 64'h10_0000, 64'h10_0fff, '0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_OVERLAP, 64'h3000, 64'h1000, '0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_CONTAIN, 64'h1800, 64'h1900, '0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_CONTAIN, 64'h9000, 64'h9fff, '0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_OPTIMIZE, '0, '0, '0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_FIND_CONTAIN, 64'h5800, 64'h5900, '0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_UNUSED6, '0, '0, '0, '0, '0, '0, '0, 1'b0),
         mk(FUNC_UNUSED7, ALL_ONES, ALL_ONES, ALL_ONES, 6'd63, 3'd6, 8'hff, 16'hffff, 1'b1)
      };
      foreach (directed[i]) send_req(directed[i]);

      limits = '{64'h8_0000, 64'h0, ALL_ONES, 64'h1, 64'h4_2000, {$urandom, $urandom}};
      for (int seg = 0; seg < 6; seg++) begin
         write_limit(limits[seg]);
         gap_pct   = (seg < 2) ? 10 : (seg < 4) ? 46 : 0;
         stall_pct = (seg < 2) ? 46 : (seg < 4) ? 10 : 0;
         repeat (122) send_req(pick_req());
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d requests (adds, searches, lookups, optimize, unused codes), %0d responses,",
               sent, responses);
      $display("under seven upper-limit settings and three idle/stall profiles.");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
